@@ rtl/core/pcx_pkg.sv @@
package pcx_pkg;

  localparam int COUNT_WIDTH_DEF = 24;
  localparam int SIZE_W          = 24;
  localparam int BYTE_W          = 8;
  localparam int RUN_LEN_W       = 6;
  localparam int QUEUE_DEPTH     = 2;
  localparam int QPTR_W          = $clog2(QUEUE_DEPTH);

  localparam logic [1:0] COUNT_MARK = 2'b11;

  typedef enum logic [1:0] {
    KIND_BEGIN,
    KIND_COUNT,
    KIND_PLAIN
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [BYTE_W-1:0]  value;
  } cmd_t;

  typedef struct packed {
    logic running;
    logic pending;
  } stat_t;

endpackage

@@ rtl/core/pcx_front.sv @@
module pcx_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                action,
  input  logic [7:0]          data_byte,
  output pcx_pkg::cmd_t       cmd,
  output logic                cmd_valid,
  input  logic                cmd_pop
);
  import pcx_pkg::*;

  cmd_t                 queue [QUEUE_DEPTH];
  logic [QPTR_W-1:0]    wr_ptr;
  logic [QPTR_W-1:0]    rd_ptr;
  logic [QPTR_W:0]      fill;
  logic                 push;
  cmd_t                 classed;

  // classify the word on the way in
  always_comb begin
    classed.value = data_byte;
    priority if (action) begin
      classed.kind = KIND_BEGIN;
    end else if (data_byte[7:6] == COUNT_MARK) begin
      classed.kind = KIND_COUNT;
    end else begin
      classed.kind = KIND_PLAIN;
    end
  end

  assign in_stall  = (fill == (QPTR_W+1)'(QUEUE_DEPTH));
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (fill != '0);
  assign cmd       = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= classed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (cmd_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, cmd_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

@@ rtl/core/pcx_back.sv @@
module pcx_back #(
  parameter int COUNT_WIDTH = pcx_pkg::COUNT_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  input  logic [23:0]         cfg_data,
  input  pcx_pkg::cmd_t       cmd,
  input  logic                cmd_valid,
  output logic                cmd_pop,
  output pcx_pkg::stat_t      stat,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          pixel_byte,
  output logic                last_of_run,
  output logic                image_complete
);
  import pcx_pkg::*;

  localparam logic [32:0] COUNT_MAX = (33'd1 << COUNT_WIDTH) - 33'd1;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  state_t                  state;
  logic [SIZE_W-1:0]       image_bytes;
  logic                    pend;
  logic [RUN_LEN_W-1:0]    plen;
  logic [COUNT_WIDTH-1:0]  bw;
  logic [RUN_LEN_W-1:0]    cnt;
  logic [BYTE_W-1:0]       val;

  logic [32:0]             size_ext;
  logic [COUNT_WIDTH-1:0]  eff;
  logic [COUNT_WIDTH-1:0]  remain;
  logic [COUNT_WIDTH-1:0]  bw_inc;
  logic                    full;
  logic                    load_ok;
  logic                    emit_req;
  logic [RUN_LEN_W-1:0]    emit_len;
  logic [RUN_LEN_W-1:0]    n;
  logic                    emit_first;
  logic                    run_load;
  logic                    complete_hit;

  // saturate the configured size to the counter range
  assign size_ext     = 33'(image_bytes);
  assign eff          = (size_ext > COUNT_MAX) ? COUNT_MAX[COUNT_WIDTH-1:0]
                                               : size_ext[COUNT_WIDTH-1:0];
  assign full         = (bw >= eff);
  assign remain       = full ? '0 : (eff - bw);
  assign bw_inc       = bw + 1'b1;
  assign complete_hit = (bw_inc == eff);
  assign load_ok      = !out_valid || !out_stall;

  always_comb begin
    emit_req = 1'b0;
    emit_len = '0;
    if (state == ST_IDLE && cmd_valid && cmd.kind != KIND_BEGIN) begin
      if (pend) begin
        emit_req = 1'b1;
        emit_len = plen;
      end else if (!full && cmd.kind == KIND_PLAIN) begin
        emit_req = 1'b1;
        emit_len = RUN_LEN_W'(1);
      end
    end
  end

  // clip the run to what is left of the image
  assign n          = (remain < COUNT_WIDTH'(emit_len)) ? remain[RUN_LEN_W-1:0] : emit_len;
  assign emit_first = emit_req && (n != '0) && load_ok;
  assign cmd_pop    = (state == ST_IDLE) && cmd_valid && (!emit_req || n == '0 || load_ok);
  assign run_load   = (state == ST_RUN) && load_ok;

  assign stat.running = (state == ST_RUN);
  assign stat.pending = pend;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      image_bytes <= SIZE_W'(1);
      pend        <= 1'b0;
      plen        <= '0;
      bw          <= '0;
      cnt         <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        image_bytes <= cfg_data;
      end
      if (emit_first || run_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (emit_first) begin
        pixel_byte     <= cmd.value;
        last_of_run    <= (n == RUN_LEN_W'(1));
        image_complete <= complete_hit;
        bw             <= bw_inc;
        if (n != RUN_LEN_W'(1)) begin
          state <= ST_RUN;
          cnt   <= n - 1'b1;
          val   <= cmd.value;
        end
      end
      if (run_load) begin
        pixel_byte     <= val;
        last_of_run    <= (cnt == RUN_LEN_W'(1));
        image_complete <= complete_hit;
        bw             <= bw_inc;
        cnt            <= cnt - 1'b1;
        if (cnt == RUN_LEN_W'(1)) begin
          state <= ST_IDLE;
        end
      end
      if (cmd_pop) begin
        unique case (cmd.kind)
          KIND_BEGIN: begin
            pend <= 1'b0;
            plen <= '0;
            bw   <= '0;
          end
          KIND_COUNT: begin
            if (pend) begin
              pend <= 1'b0;
              plen <= '0;
            end else if (!full) begin
              pend <= 1'b1;
              plen <= cmd.value[RUN_LEN_W-1:0];
            end
          end
          KIND_PLAIN: begin
            pend <= 1'b0;
            plen <= '0;
          end
          default: ;
        endcase
      end
    end
  end

endmodule

@@ rtl/core/pcx_rle_decoder.sv @@
// PCX run-length decoder. Each input word is either a begin action, which
// restarts the image count, or one encoded stream byte. Literals stream at
// one word a cycle while no run is active and out_stall is low; a count byte
// and its value byte take two input words and then produce up to 63 output
// words, one per cycle, during which the input side keeps filling a two-entry
// command queue and then stalls. Output rate is set by the single output
// register of the run engine: one decoded byte per cycle when out_stall is low.
// Runs are clipped at the configured image size, and once the image is full
// all data words are dropped until the next begin. Write image_bytes only
// while the block is idle; cfg_ready is always high.
module pcx_rle_decoder #(
  parameter int COUNT_WIDTH = pcx_pkg::COUNT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        action,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  pixel_byte,
  output logic        last_of_run,
  output logic        image_complete,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [23:0] cfg_data
);
  import pcx_pkg::*;

  cmd_t   cmd;
  logic   cmd_valid;
  logic   cmd_pop;
  stat_t  stat;

  assign cfg_ready = 1'b1;

  pcx_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .action    (action),
    .data_byte (data_byte),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop)
  );

  pcx_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid && cfg_ready),
    .cfg_data       (cfg_data),
    .cmd            (cmd),
    .cmd_valid      (cmd_valid),
    .cmd_pop        (cmd_pop),
    .stat           (stat),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .pixel_byte     (pixel_byte),
    .last_of_run    (last_of_run),
    .image_complete (image_complete)
  );

`ifndef SYNTH
  // the byte that fills the image always ends its run
  a_complete_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && image_complete |-> last_of_run)
    else $error("image_complete without last_of_run");

  // hold the queue head while a run is being emitted
  a_no_pop_in_run: assert property (@(posedge clk) disable iff (rst)
    stat.running |-> !cmd_pop)
    else $error("command popped during a run");

  a_no_pending_in_run: assert property (@(posedge clk) disable iff (rst)
    stat.running |-> !stat.pending)
    else $error("count pending while a run is active");
`endif

endmodule

@@ verif/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pcx_pkg::*;

  localparam logic ACT_DATA  = 1'b0;
  localparam logic ACT_BEGIN = 1'b1;
  localparam int   IDLE_TAIL = 16;
  localparam int   END_TAIL  = 80;

  typedef struct packed {
    logic [BYTE_W-1:0] pixel;
    logic              last;
    logic              done;
  } pix_t;

  // hand-read expectation for an opening row: result count and first result
  typedef struct packed {
    logic              on;
    logic [6:0]        n;
    logic [BYTE_W-1:0] pix;
    logic              last;
    logic              done;
  } pin_t;

  typedef enum logic {ROW_WORD, ROW_SIZE} row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    logic              act;
    logic [BYTE_W-1:0] val;
    logic [SIZE_W-1:0] size;
    pin_t              pin;
  } row_t;

  localparam pin_t NO_PIN = '0;
  localparam pin_t PIN_NONE_OUT = '{1'b1, 7'd0, 8'h00, 1'b0, 1'b0};

  row_t opening_rows [28] = '{
    '{ROW_WORD, ACT_DATA,  8'h00, 24'd0, '{1'b1, 7'd1, 8'h00, 1'b1, 1'b1}},
    '{ROW_WORD, ACT_DATA,  8'h55, 24'd0, PIN_NONE_OUT},
    '{ROW_WORD, ACT_DATA,  8'hC5, 24'd0, PIN_NONE_OUT},
    '{ROW_WORD, ACT_DATA,  8'h12, 24'd0, PIN_NONE_OUT},
    '{ROW_WORD, ACT_BEGIN, 8'h00, 24'd0, PIN_NONE_OUT},
    '{ROW_SIZE, ACT_DATA,  8'h00, 24'hFFFFFF, NO_PIN},
    '{ROW_WORD, ACT_BEGIN, 8'hA5, 24'd0, PIN_NONE_OUT},
    '{ROW_WORD, ACT_DATA,  8'hFF, 24'd0, PIN_NONE_OUT},
    '{ROW_WORD, ACT_DATA,  8'hAB, 24'd0, '{1'b1, 7'd63, 8'hAB, 1'b0, 1'b0}},
    '{ROW_WORD, ACT_DATA,  8'hC0, 24'd0, NO_PIN},
    '{ROW_WORD, ACT_DATA,  8'h77, 24'd0, PIN_NONE_OUT},
    '{ROW_WORD, ACT_DATA,  8'hC1, 24'd0, NO_PIN},
    '{ROW_WORD, ACT_DATA,  8'hC0, 24'd0, '{1'b1, 7'd1, 8'hC0, 1'b1, 1'b0}},
    '{ROW_WORD, ACT_DATA,  8'hBF, 24'd0, '{1'b1, 7'd1, 8'hBF, 1'b1, 1'b0}},
    '{ROW_WORD, ACT_DATA,  8'h3F, 24'd0, NO_PIN},
    '{ROW_WORD, ACT_DATA,  8'h80, 24'd0, NO_PIN},
    '{ROW_WORD, ACT_DATA,  8'h40, 24'd0, NO_PIN},
    '{ROW_WORD, ACT_DATA,  8'hC4, 24'd0, NO_PIN},
    // shrink below the count with a run still pending
    '{ROW_SIZE, ACT_DATA,  8'h00, 24'd5, NO_PIN},
    '{ROW_WORD, ACT_DATA,  8'h99, 24'd0, PIN_NONE_OUT},
    '{ROW_WORD, ACT_DATA,  8'h01, 24'd0, PIN_NONE_OUT},
    '{ROW_WORD, ACT_BEGIN, 8'h00, 24'd0, PIN_NONE_OUT},
    '{ROW_WORD, ACT_DATA,  8'hC8, 24'd0, NO_PIN},
    '{ROW_WORD, ACT_DATA,  8'h5A, 24'd0, '{1'b1, 7'd5, 8'h5A, 1'b0, 1'b0}},
    '{ROW_WORD, ACT_DATA,  8'h33, 24'd0, PIN_NONE_OUT},
    '{ROW_SIZE, ACT_DATA,  8'h00, 24'd0, NO_PIN},
    '{ROW_WORD, ACT_BEGIN, 8'h00, 24'd0, PIN_NONE_OUT},
    '{ROW_WORD, ACT_DATA,  8'h10, 24'd0, PIN_NONE_OUT}
  };

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              action = ACT_DATA;
  logic [BYTE_W-1:0] data_byte = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [BYTE_W-1:0] pixel_byte;
  logic              last_of_run;
  logic              image_complete;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [SIZE_W-1:0] cfg_data = '0;

  pin_t word_pin = NO_PIN;
  bit   calm = 1'b0;
  int   rx_hold = 0;
  int   fail_count = 0;

  // decoder image: size register and run/count state
  logic [SIZE_W-1:0]          img_size = 24'd1;
  logic                       run_armed = 1'b0;
  logic [RUN_LEN_W-1:0]       run_len = '0;
  logic [COUNT_WIDTH_DEF-1:0] img_written = '0;
  pix_t                       pixel_q [$];

  pcx_rle_decoder DUT (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .action         (action),
    .data_byte      (data_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .pixel_byte     (pixel_byte),
    .last_of_run    (last_of_run),
    .image_complete (image_complete),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // size fits the 24-bit counter, so no saturation is needed
  function automatic int emit_run(input logic [BYTE_W-1:0] value, input int count);
    logic [COUNT_WIDTH_DEF-1:0] remain;
    int n;
    remain = (img_written < img_size) ? img_size - img_written : '0;
    n = (count < remain) ? count : int'(remain);
    for (int k = 0; k < n; k++) begin
      img_written = img_written + 1'b1;
      pixel_q.push_back('{value, (k + 1 == n), (img_written == img_size)});
    end
    return n;
  endfunction

  function automatic int decode_word(input logic act, input logic [BYTE_W-1:0] b);
    int len;
    if (act == ACT_BEGIN) begin
      run_armed   = 1'b0;
      run_len     = '0;
      img_written = '0;
      return 0;
    end
    if (run_armed) begin
      len       = int'(run_len);
      run_armed = 1'b0;
      run_len   = '0;
      return emit_run(b, len);
    end
    if (img_written >= img_size) return 0;
    if (b[7:6] == COUNT_MARK) begin
      run_armed = 1'b1;
      run_len   = b[RUN_LEN_W-1:0];
      return 0;
    end
    return emit_run(b, 1);
  endfunction

  always @(posedge clk) begin : scoreboard
    int   base;
    int   n;
    pix_t want;
    if (rst) begin
      img_size    = 24'd1;
      run_armed   = 1'b0;
      run_len     = '0;
      img_written = '0;
    end else begin
      if (cfg_valid && cfg_ready === 1'b1) img_size = cfg_data;
      if (in_valid && in_stall === 1'b0) begin
        base = pixel_q.size();
        n = decode_word(action, data_byte);
        if (word_pin.on) begin
          if (n != word_pin.n) begin
            $error("result count expected %0d got %0d", word_pin.n, n);
            fail_count++;
          end else if (n > 0 && pixel_q[base] != {word_pin.pix, word_pin.last, word_pin.done}) begin
            $error("first result expected %02h/%0b/%0b got %02h/%0b/%0b", word_pin.pix,
                   word_pin.last, word_pin.done, pixel_q[base].pixel, pixel_q[base].last,
                   pixel_q[base].done);
            fail_count++;
          end
        end
      end
      if (out_valid === 1'b1 && !out_stall) begin
        if (pixel_q.size() == 0) begin
          $error("pixel_byte %02h arrived with no word expected", pixel_byte);
          fail_count++;
        end else begin
          want = pixel_q.pop_front();
          if (pixel_byte !== want.pixel) begin
            $error("pixel_byte expected %02h got %02h", want.pixel, pixel_byte);
            fail_count++;
          end
          if (last_of_run !== want.last) begin
            $error("last_of_run expected %0b got %0b", want.last, last_of_run);
            fail_count++;
          end
          if (image_complete !== want.done) begin
            $error("image_complete expected %0b got %0b", want.done, image_complete);
            fail_count++;
          end
        end
      end
    end
  end

  // output side: random stall per word, plus a long hold on request
  initial begin : receiver
    int w;
    forever begin
      if (rx_hold > 0) begin
        out_stall <= 1'b1;
        repeat (rx_hold) @(posedge clk);
        rx_hold = 0;
      end
      w = calm ? 0 : $urandom_range(0, 3);
      if (w > 0) begin
        out_stall <= 1'b1;
        repeat (w) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (out_valid !== 1'b1 && rx_hold == 0) @(posedge clk);
    end
  end

  task automatic push_word(input logic act, input logic [BYTE_W-1:0] b, input pin_t pin);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    action    <= act;
    data_byte <= b;
    word_pin  <= pin;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
  endtask

  task automatic drain_pixels();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pixel_q.size() != 0) @(posedge clk);
  endtask

  // words that make no result may still be in flight once the queue is empty
  task automatic settle();
    drain_pixels();
    repeat (IDLE_TAIL) @(posedge clk);
  endtask

  task automatic write_size(input logic [SIZE_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_stream(input int budget);
    int sent;
    int r;
    int len;
    sent = 0;
    while (sent < budget) begin
      r = $urandom_range(0, 99);
      if (img_written >= img_size && $urandom_range(0, 3) != 0) begin
        push_word(ACT_BEGIN, BYTE_W'($urandom_range(0, 255)), NO_PIN);
        sent++;
      end else if (r < 45) begin
        push_word(ACT_DATA, BYTE_W'($urandom_range(0, 191)), NO_PIN);
        sent++;
      end else if (r < 85) begin
        len = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 12) : $urandom_range(0, 63);
        push_word(ACT_DATA, {COUNT_MARK, len[RUN_LEN_W-1:0]}, NO_PIN);
        push_word(ACT_DATA, BYTE_W'($urandom_range(0, 255)), NO_PIN);
        sent += 2;
      end else if (r < 90) begin
        push_word(ACT_BEGIN, BYTE_W'($urandom_range(0, 255)), NO_PIN);
        sent++;
      end else if (r < 95) begin
        push_word(ACT_DATA, BYTE_W'($urandom_range(0, 255)), NO_PIN);
        sent++;
      end else begin
        // count word cut off by a begin
        push_word(ACT_DATA, {COUNT_MARK, 6'($urandom_range(0, 63))}, NO_PIN);
        push_word(ACT_BEGIN, BYTE_W'($urandom_range(0, 255)), NO_PIN);
        sent += 2;
      end
    end
  endtask

  initial begin : stimulus
    logic [SIZE_W-1:0] sizes [7];
    int                budgets [7];
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (opening_rows[i]) begin
      if (opening_rows[i].kind == ROW_SIZE) begin
        settle();
        write_size(opening_rows[i].size);
      end else begin
        push_word(opening_rows[i].act, opening_rows[i].val, opening_rows[i].pin);
      end
    end

    sizes[0] = SIZE_W'($urandom_range(1, 48));    budgets[0] = 40;
    sizes[1] = 24'hFFFFFF;                        budgets[1] = 40;
    sizes[2] = 24'd1;                             budgets[2] = 25;
    sizes[3] = 24'd0;                             budgets[3] = 10;
    sizes[4] = SIZE_W'($urandom_range(64, 300));  budgets[4] = 50;
    sizes[5] = SIZE_W'($urandom);                 budgets[5] = 40;
    sizes[6] = SIZE_W'($urandom_range(2, 9));     budgets[6] = 30;

    for (int p = 0; p < 7; p++) begin
      settle();
      write_size(sizes[p]);
      push_word(ACT_BEGIN, BYTE_W'($urandom_range(0, 255)), NO_PIN);
      if (p == 1) begin
        // hold the output long enough to back up the input side
        calm = 1'b1;
        rx_hold = 150;
        repeat (6) begin
          push_word(ACT_DATA, {COUNT_MARK, 6'd40}, NO_PIN);
          push_word(ACT_DATA, BYTE_W'($urandom_range(0, 255)), NO_PIN);
        end
        drain_pixels();
        calm = 1'b0;
      end
      calm = (p == 4);
      send_stream(budgets[p]);
      calm = 1'b0;
    end

    settle();
    repeat (END_TAIL) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #4_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

@@ pcx_rle_decoder.f @@
rtl/core/pcx_pkg.sv
rtl/core/pcx_front.sv
rtl/core/pcx_back.sv
rtl/core/pcx_rle_decoder.sv
verif/tb_top.sv
